>>> rtl/xalu_pkg.sv
// package for the integer alu with flags: operation codes, controller states
// and the command/status structs between controller and datapath
// no dependencies
package xalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_ADC  = 4'd1,
    OP_SUB  = 4'd2,
    OP_SBB  = 4'd3,
    OP_AND  = 4'd4,
    OP_OR   = 4'd5,
    OP_XOR  = 4'd6,
    OP_SHL  = 4'd7,
    OP_SHR  = 4'd8,
    OP_SAR  = 4'd9,
    OP_MUL  = 4'd10,
    OP_IMUL = 4'd11,
    OP_DIV  = 4'd12,
    OP_IDIV = 4'd13,
    OP_MOD  = 4'd14,
    OP_IMOD = 4'd15
  } op_t;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;

  localparam int DIV_STEPS = 64;
  localparam int CNT_W     = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_PREP,
    ST_DIV,
    ST_DIV_FIX,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec_simple;
    logic mul_finish;
    logic div_init;
    logic div_step;
    logic div_fix;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_zero;
  } status_t;

endpackage

>>> rtl/x86_integer_alu_with_flags_unit.sv
// integer alu with stored cf/pf/zf/sf/of flags
// after the accept, add..sar and a zero divisor pass the decode state to the done state,
// mul/imul add a finish state, divide and modulo the 64-step radix-2 divider and a fix state
// busy is low in the idle state, where a word is accepted, and high through the done cycle,
// so a new word is taken only after done, one word in flight at a time; the receiver cannot stall
// synchronous reset clears the flags and returns the controller to idle
module x86_integer_alu_with_flags_unit import xalu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [3:0]  action,
  input  logic [1:0]  size_code,
  input  logic [31:0] src,
  input  logic [63:0] dest,
  output logic [63:0] result,
  output logic        carry_flag,
  output logic        parity_flag,
  output logic        zero_flag,
  output logic        sign_flag,
  output logic        overflow_flag,
  output logic        divide_error
);

  cmd_t    cmd;
  status_t stat;

  xalu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .stat(stat), .cmd(cmd)
  );

  xalu_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .action(action), .size_code(size_code), .src(src), .dest(dest),
    .result(result), .carry_flag(carry_flag), .parity_flag(parity_flag),
    .zero_flag(zero_flag), .sign_flag(sign_flag),
    .overflow_flag(overflow_flag), .divide_error(divide_error)
  );

endmodule

>>> rtl/xalu_datapath.sv
// datapath of the integer alu: operand registers, combinational simple ops,
// registered multiplier and a radix-2 restoring divider, flag register
// depends on xalu_pkg
module xalu_datapath import xalu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     stat,
  input  logic [3:0]  action,
  input  logic [1:0]  size_code,
  input  logic [31:0] src,
  input  logic [63:0] dest,
  output logic [63:0] result,
  output logic        carry_flag,
  output logic        parity_flag,
  output logic        zero_flag,
  output logic        sign_flag,
  output logic        overflow_flag,
  output logic        divide_error
);

  op_t         op;
  logic [1:0]  sz;
  logic [31:0] s_reg;
  logic [63:0] d_reg;
  logic [4:0]  flags;   // bit 0 CF, 1 PF, 2 ZF, 3 SF, 4 OF
  logic [63:0] prod;
  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] dvd;
  logic [63:0] dvs;
  logic        neg_q;
  logic        neg_r;
  logic [63:0] res_reg;
  logic        err_reg;

  logic [31:0] m;
  logic [5:0]  bits;
  logic [4:0]  top;
  logic [31:0] sm;
  logic [31:0] d;
  logic [31:0] dsx;
  logic [31:0] ssx;

  always_comb begin
    unique case (sz)
      SIZE_8:  begin m = 32'hFF;   bits = 6'd8;  end
      SIZE_16: begin m = 32'hFFFF; bits = 6'd16; end
      default: begin m = 32'hFFFFFFFF; bits = 6'd32; end
    endcase
    top = 5'(bits - 6'd1);
    sm  = s_reg & m;
    d   = d_reg[31:0] & m;
    dsx = d_reg[top] ? (d | ~m) : d;
    ssx = s_reg[top] ? (sm | ~m) : sm;
  end

  assign stat.is_mul   = (op == OP_MUL) || (op == OP_IMUL);
  assign stat.is_div   = op[3:2] == 2'b11;
  assign stat.div_zero = (sm == 32'd0);

  // simple ops
  logic [32:0] w;
  logic [31:0] r;
  logic        cf_n;
  logic        of_n;
  logic        upd_all;
  logic        upd;
  logic [4:0]  n;
  logic [63:0] sh;
  logic        cin;

  always_comb begin
    cin     = flags[0];
    w       = '0;
    r       = '0;
    cf_n    = 1'b0;
    of_n    = 1'b0;
    upd     = 1'b1;
    n       = s_reg[4:0];
    sh      = '0;
    unique case (op)
      OP_ADD, OP_ADC: begin
        w    = {1'b0, d} + {1'b0, sm} + {32'd0, (op == OP_ADC) & cin};
        r    = w[31:0] & m;
        cf_n = w[bits];
        of_n = (~(d[top] ^ sm[top])) & (d[top] ^ r[top]);
      end
      OP_SUB, OP_SBB: begin
        w    = {1'b0, d} - {1'b0, sm} - {32'd0, (op == OP_SBB) & cin};
        r    = w[31:0] & m;
        cf_n = w[32];
        of_n = (d[top] ^ sm[top]) & (d[top] ^ r[top]);
      end
      OP_AND: r = d & sm;
      OP_OR:  r = d | sm;
      OP_XOR: r = d ^ sm;
      OP_SHL: begin
        sh   = {32'd0, d} << n;
        r    = sh[31:0] & m;
        cf_n = sh[bits];
        of_n = r[top] ^ cf_n;
        upd  = n != 5'd0;
      end
      OP_SHR: begin
        sh   = {d, 32'd0} >> n;
        r    = sh[63:32] & m;
        cf_n = sh[31];
        of_n = d[top];
        upd  = n != 5'd0;
      end
      OP_SAR: begin
        sh   = 64'($signed({dsx, 32'd0}) >>> n);
        r    = sh[63:32] & m;
        cf_n = sh[31];
        of_n = 1'b0;
        upd  = n != 5'd0;
      end
      default: ;
    endcase
    upd_all = upd;
  end

  // multiplier operands registered, product registered
  logic [63:0] mul_p;
  logic [63:0] mul_w;
  logic [63:0] mul_mask;
  logic        mul_cf;
  logic [31:0] pl;
  logic [31:0] plx;

  assign mul_p = (op == OP_IMUL) ? 64'($signed(dsx) * $signed(ssx))
                                 : {32'd0, d} * {32'd0, sm};
  always_comb begin
    unique case (sz)
      SIZE_8:  mul_mask = 64'hFFFF;
      SIZE_16: mul_mask = 64'hFFFFFFFF;
      default: mul_mask = '1;
    endcase
    mul_w = prod;
    pl    = mul_w[31:0] & m;
    plx   = mul_w[top] ? (pl | ~m) : pl;
    if (op == OP_IMUL) begin
      mul_cf = {{32{plx[31]}}, plx} != mul_w;
    end else begin
      mul_cf = (mul_w >> bits) != 64'd0;
    end
  end

  // divider: restoring, one quotient bit per cycle
  logic [63:0] ua;
  logic [63:0] ub;
  logic        na;
  logic        nb;
  logic        signed_div;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic [63:0] q_fix;
  logic [63:0] r_fix;

  always_comb begin
    signed_div = (op == OP_IDIV) || (op == OP_IMOD);
    na   = signed_div & d_reg[63];
    nb   = signed_div & ssx[31];
    ua   = na ? (64'd0 - d_reg) : d_reg;
    ub   = signed_div ? (nb ? (64'd0 - {{32{ssx[31]}}, ssx})
                            : {{32{ssx[31]}}, ssx}) : {32'd0, sm};
    rem_sh = {rem[62:0], dvd[63]};
    trial  = {1'b0, rem_sh} - {1'b0, dvs};
    q_fix  = neg_q ? (64'd0 - quo) : quo;
    r_fix  = neg_r ? (64'd0 - rem) : rem;
  end

  function automatic logic parity_even(input logic [7:0] v);
    parity_even = ~^v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      flags   <= '0;
      err_reg <= 1'b0;
    end else begin
      if (cmd.load) begin
        op    <= op_t'(action);
        sz    <= size_code;
        s_reg <= src;
        d_reg <= dest;
      end
      if (cmd.exec_simple) begin
        err_reg <= 1'b0;
        res_reg <= {32'd0, r};
        if (upd_all) begin
          flags <= {of_n, r[top], (r == 32'd0), parity_even(r[7:0]), cf_n};
        end
      end
      if (cmd.mul_finish) begin
        err_reg  <= 1'b0;
        res_reg  <= prod & mul_mask;
        flags[0] <= mul_cf;
        flags[4] <= mul_cf;
      end
      prod <= mul_p;
      if (cmd.div_init) begin
        err_reg <= stat.div_zero;
        res_reg <= '0;
        dvd     <= ua;
        dvs     <= ub;
        rem     <= '0;
        quo     <= '0;
        neg_q   <= na ^ nb;
        neg_r   <= na;
      end
      if (cmd.div_step) begin
        dvd <= {dvd[62:0], 1'b0};
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
      end
      if (cmd.div_fix) begin
        res_reg <= ((op == OP_DIV || op == OP_IDIV) ? q_fix : r_fix) & {32'd0, m};
      end
    end
  end

  assign result        = cmd.emit ? res_reg : '0;
  assign carry_flag    = flags[0];
  assign parity_flag   = flags[1];
  assign zero_flag     = flags[2];
  assign sign_flag     = flags[3];
  assign overflow_flag = flags[4];
  assign divide_error  = cmd.emit & err_reg;

endmodule

>>> rtl/xalu_ctrl.sv
// controller state machine of the integer alu
// depends on xalu_pkg
module xalu_ctrl import xalu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    done,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        // decode cycle; product registers here for mul
        if (stat.is_div) begin
          cmd.div_init = 1'b1;
          state_next   = stat.div_zero ? ST_DONE : ST_DIV;
          cnt_next     = '0;
        end else if (stat.is_mul) begin
          state_next = ST_DIV_PREP;
        end else begin
          cmd.exec_simple = 1'b1;
          state_next      = ST_DONE;
        end
      end
      ST_DIV_PREP: begin
        cmd.mul_finish = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit   = 1'b1;
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
